// ===== rtl/fixed_point_q24_8_alu_defines.svh =====
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared helpers for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// Checks that a condition implies a consequence on the same clock edge.
`define FPA_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence on the next clock edge.
`define FPA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Action codes, default widths and the token passed down the divide chain.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
  localparam int FracBitsDef  = 8;
  localparam int DataWidthDef = 32;
  localparam int ActWidth     = 4;

  typedef enum logic [ActWidth-1:0] {
    ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
    ACT_MIN = 4'd4, ACT_MAX = 4'd5, ACT_INC = 4'd6, ACT_DEC = 4'd7,
    ACT_I2F = 4'd8, ACT_F2I = 4'd9
  } action_t;

  typedef struct packed {
    logic lt;
    logic gt;
    logic eq;
    logic ovf;
    logic dz;
  } flags_t;
endpackage
`default_nettype wire

// ===== rtl/fpa_cell.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU chain cell
// One restoring divide step; carries the finished result of other actions.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_cell #(
  parameter int W  = 32,
  parameter int QW = 48
) (
  input  wire logic                  clk,
  input  wire logic                  adv,
  input  wire logic                  div_i,
  input  wire logic [W-1:0]          rem_i,
  input  wire logic [QW-1:0]         num_i,
  input  wire logic [W-1:0]          den_i,
  input  wire logic                  neg_i,
  input  wire logic [W-1:0]          res_i,
  input  wire fpa_pkg::flags_t       flg_i,
  output logic                       div_o,
  output logic [W-1:0]               rem_o,
  output logic [QW-1:0]              num_o,
  output logic [W-1:0]               den_o,
  output logic                       neg_o,
  output logic [W-1:0]               res_o,
  output fpa_pkg::flags_t            flg_o
);
  import fpa_pkg::*;
  logic [W:0]  trial;
  logic [W:0]  diff;
  logic        take;
  logic [W-1:0] rem_nxt;
  logic [QW-1:0] num_nxt;

  always_comb begin
    trial   = {rem_i, num_i[QW-1]};
    diff    = trial - {1'b0, den_i};
    take    = !diff[W];
    rem_nxt = take ? diff[W-1:0] : trial[W-1:0];
    num_nxt = {num_i[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_o <= div_i;
      rem_o <= div_i ? rem_nxt : rem_i;
      num_o <= div_i ? num_nxt : num_i;
      den_o <= den_i;
      neg_o <= neg_i;
      res_o <= res_i;
      flg_o <= flg_i;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fixed_point_q24_8_alu.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU, signed Q24.8
// Ten actions with rounding half away from zero and saturation.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// in_       in   tdata: operand_a[31:0], operand_b[63:32]; tuser: action[3:0]
// out_      out  tdata: result[31:0]; tuser: a_less, a_greater, a_equal,
//                overflow, divide_by_zero
// One beat enters per cycle while the output register is free or taken; every
// result passes DATA_WIDTH+FRAC_BITS+3 register stages, set by the chain of
// one-bit divide cells that all actions pass.
// The whole chain moves only when the output register is free or taken.
// Reset is synchronous and clears the valid bits of all stages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_q24_8_alu_defines.svh"
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS  = fpa_pkg::FracBitsDef,
  parameter int DATA_WIDTH = fpa_pkg::DataWidthDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [2*DATA_WIDTH-1:0] in_tdata,  // operand_a, operand_b
  input  wire logic [3:0]              in_tuser,  // action
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [DATA_WIDTH-1:0]        out_tdata, // result
  output logic [4:0]                   out_tuser  // lt, gt, eq, ovf, dz
);
  import fpa_pkg::*;
  localparam int W  = DATA_WIDTH;
  localparam int QW = W + FRAC_BITS;
  localparam int N  = QW;
  localparam int PW = 2 * W;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage 0: decode, compares, sign/magnitude split.
  logic          s0_v_r;
  action_t       s0_act_r;
  logic [W-1:0]  s0_a_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (adv) s0_v_r <= in_tvalid;
    if (adv) begin
      s0_act_r <= action_t'(in_tuser);
      s0_a_r   <= in_tdata[W-1:0];
      s0_b_r   <= in_tdata[2*W-1:W];
    end
  end

  logic          na, nb;
  logic [W-1:0]  ma, mb;
  logic [W:0]    ea, eb;
  flags_t        f0;
  assign na = s0_a_r[W-1];
  assign nb = s0_b_r[W-1];
  assign ma = na ? W'(-s0_a_r) : s0_a_r;
  assign mb = nb ? W'(-s0_b_r) : s0_b_r;
  assign ea = {s0_a_r[W-1], s0_a_r};
  assign eb = {s0_b_r[W-1], s0_b_r};

  // Stage 1: product or sum, still unsaturated.
  logic          s1_v_r;
  action_t       s1_act_r;
  logic [PW-1:0] s1_prd_r;
  logic [W+1:0]  s1_sum_r;
  logic          s1_neg_r;
  logic [W-1:0]  s1_a_r, s1_b_r, s1_ma_r, s1_mb_r;
  flags_t        s1_f_r;
  logic [W+1:0]  sum0;

  always_comb begin
    f0 = '0;
    f0.lt = $signed(s0_a_r) < $signed(s0_b_r);
    f0.gt = $signed(s0_a_r) > $signed(s0_b_r);
    f0.eq = s0_a_r == s0_b_r;
    f0.dz = (s0_act_r == ACT_DIV) && (mb == '0);
    unique case (s0_act_r)
      ACT_SUB: sum0 = {ea[W], ea} - {eb[W], eb};
      ACT_INC: sum0 = {ea[W], ea} + (W+2)'(1);
      ACT_DEC: sum0 = {ea[W], ea} - (W+2)'(1);
      default: sum0 = {ea[W], ea} + {eb[W], eb};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= s0_v_r;
    if (adv) begin
      s1_act_r <= s0_act_r;
      s1_prd_r <= PW'(ma) * PW'(mb);
      s1_sum_r <= sum0;
      s1_neg_r <= (s0_act_r == ACT_I2F || s0_act_r == ACT_F2I) ? na : (na ^ nb);
      s1_a_r   <= s0_a_r;
      s1_b_r   <= s0_b_r;
      s1_ma_r  <= ma;
      s1_mb_r  <= mb;
      s1_f_r   <= f0;
    end
  end

  // Saturation of a sign and wide magnitude.
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

  logic [PW:0]   rmag;
  logic [PW:0]   i2f;
  logic [W-1:0]  res1;
  logic          ovf1;
  logic          div1;

  always_comb begin
    rmag = (FRAC_BITS == 0) ? {1'b0, s1_prd_r}
         : (({1'b0, s1_prd_r} + ((PW+1)'(1) << (FRAC_BITS - (FRAC_BITS > 0 ? 1 : 0))))
            >> FRAC_BITS);
    i2f  = (PW+1)'(s1_ma_r) << FRAC_BITS;
    res1 = '0;
    ovf1 = 1'b0;
    div1 = 1'b0;
    unique case (s1_act_r)
      ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
        if (s1_sum_r[W+1:W-1] != {3{s1_sum_r[W+1]}}) begin
          ovf1 = 1'b1;
          res1 = s1_sum_r[W+1] ? MinNeg : MaxPos;
        end else res1 = s1_sum_r[W-1:0];
      end
      ACT_MUL, ACT_I2F, ACT_F2I: begin
        if (s1_act_r == ACT_I2F) rmag = i2f;
        else if (s1_act_r == ACT_F2I)
          rmag = (FRAC_BITS == 0) ? (PW+1)'(s1_ma_r)
               : (((PW+1)'(s1_ma_r) + ((PW+1)'(1) << (FRAC_BITS - (FRAC_BITS > 0 ? 1 : 0))))
                  >> FRAC_BITS);
        if (!s1_neg_r && rmag > (PW+1)'(MaxPos)) begin
          ovf1 = 1'b1; res1 = MaxPos;
        end else if (s1_neg_r && rmag > (PW+1)'(MinNeg)) begin
          ovf1 = 1'b1; res1 = MinNeg;
        end else res1 = s1_neg_r ? W'(-rmag[W-1:0]) : rmag[W-1:0];
      end
      ACT_MIN: res1 = s1_f_r.lt ? s1_a_r : s1_b_r;
      ACT_MAX: res1 = s1_f_r.gt ? s1_a_r : s1_b_r;
      ACT_DIV: div1 = !s1_f_r.dz;
      default: res1 = '0;
    endcase
  end

  flags_t f1;
  always_comb begin
    f1 = s1_f_r;
    f1.ovf = ovf1;
  end

  // Divide chain.
  logic          cv   [N+1];
  logic          cdiv [N+1];
  logic [W-1:0]  crem [N+1];
  logic [QW-1:0] cnum [N+1];
  logic [W-1:0]  cden [N+1];
  logic          cneg [N+1];
  logic [W-1:0]  cres [N+1];
  flags_t        cflg [N+1];

  assign cdiv[0] = div1;
  assign crem[0] = '0;
  assign cnum[0] = QW'(s1_ma_r) << FRAC_BITS;
  assign cden[0] = s1_mb_r;
  assign cneg[0] = s1_neg_r;
  assign cres[0] = res1;
  assign cflg[0] = f1;
  assign cv[0]   = s1_v_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fpa_cell #(.W(W), .QW(QW)) u_cell (
      .clk(clk), .adv(adv),
      .div_i(cdiv[i]), .rem_i(crem[i]), .num_i(cnum[i]), .den_i(cden[i]),
      .neg_i(cneg[i]), .res_i(cres[i]), .flg_i(cflg[i]),
      .div_o(cdiv[i+1]), .rem_o(crem[i+1]), .num_o(cnum[i+1]), .den_o(cden[i+1]),
      .neg_o(cneg[i+1]), .res_o(cres[i+1]), .flg_o(cflg[i+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
    end
  end

  // Final rounding of the quotient, then the output register.
  logic [QW:0]   qr;
  logic [W-1:0]  resf;
  flags_t        ff;
  logic [W:0]    rem2;

  always_comb begin
    ff   = cflg[N];
    resf = cres[N];
    rem2 = {1'b0, crem[N]};
    qr   = {1'b0, cnum[N]} + (QW+1)'((rem2 << 1) >= {1'b0, cden[N]});
    if (cdiv[N]) begin
      if (!cneg[N] && qr > (QW+1)'(MaxPos)) begin
        ff.ovf = 1'b1; resf = MaxPos;
      end else if (cneg[N] && qr > (QW+1)'(MinNeg)) begin
        ff.ovf = 1'b1; resf = MinNeg;
      end else resf = cneg[N] ? W'(-qr[W-1:0]) : qr[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= cv[N];
    if (adv) begin
      out_tdata <= resf;
      out_tuser <= {ff.dz, ff.ovf, ff.eq, ff.gt, ff.lt};
    end
  end

  `FPA_ASSERT_IMP(a_dz_zero, clk, rst_n, out_tvalid && out_tuser[4], out_tdata == '0 && !out_tuser[3], "divide by zero must give zero without overflow")
  `FPA_ASSERT_IMP(a_cmp_one, clk, rst_n, out_tvalid, $onehot({out_tuser[0], out_tuser[1], out_tuser[2]}), "exactly one compare flag expected")
  `FPA_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result must hold")
endmodule
`default_nettype wire
